>>> rtl/core/sasm_pkg.sv
// Shared types and constants for the Shift-And string matcher.
// Depends on nothing; every other file of the block imports it.
package sasm_pkg;

  localparam int OPCODE_W = 2;
  localparam int SYMBOL_W = 5;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 6;
  localparam int INDEX_W  = 32;

  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TEXT  = 2'd2;

  typedef struct packed {
    logic                clear;
    logic                load;
    logic                text;
    logic                sym_ok;
    logic [SYMBOL_W-1:0] symbol;
  } sasm_ctrl_t;

endpackage

>>> rtl/core/sasm_in_if.sv
// Input channel of the matcher: opcode, symbol and pattern position.
// Depends on sasm_pkg for the field widths.
interface sasm_in_if;
  import sasm_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SYMBOL_W-1:0] symbol;
  logic [POS_W-1:0]    position;

  modport source (output valid, output opcode, output symbol, output position, input ready);
  modport sink   (input valid, input opcode, input symbol, input position, output ready);
endinterface

>>> rtl/core/sasm_out_if.sv
// Result channel of the matcher: match flag and start index.
// Depends on sasm_pkg for the field widths.
interface sasm_out_if;
  import sasm_pkg::*;

  logic               valid;
  logic               ready;
  logic               match;
  logic [INDEX_W-1:0] match_start;

  modport source (output valid, output match, output match_start, input ready);
  modport sink   (input valid, input match, input match_start, output ready);
endinterface

>>> rtl/core/sasm_cell.sv
// One pattern position: its column of the symbol mask table and its match bit.
// Depends on sasm_pkg for the control struct.
module sasm_cell import sasm_pkg::*; #(
  parameter int ALPHABET = 26
) (
  input  logic       clk,
  input  logic       rst,
  input  sasm_ctrl_t ctrl,
  input  logic       load_sel,
  input  logic       prev_bit,
  output logic       state_bit,
  output logic       next_bit
);

  localparam int SymW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

  logic [ALPHABET-1:0] column;
  logic [SymW-1:0]     sym_idx;

  assign sym_idx  = SymW'(ctrl.symbol);
  assign next_bit = prev_bit & ctrl.sym_ok & column[sym_idx];

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      column    <= '0;
      state_bit <= 1'b0;
    end else begin
      if (load_sel) begin
        column[sym_idx] <= 1'b1;
      end
      if (ctrl.text) begin
        state_bit <= next_bit;
      end
    end
  end

endmodule

>>> rtl/core/shift_and_string_matcher.sv
// Shift-And exact string matcher. One transaction is accepted in every cycle while the
// output stage has room, and its result is registered there; the rate is set by the
// row of pattern cells, which update the whole match vector together. A clear
// transaction empties the mask table, the match vector and the text counter at once.
// The output stage holds two results, so input is taken while one result waits.
module shift_and_string_matcher import sasm_pkg::*; #(
  parameter int MAX_PATTERN = 63,
  parameter int ALPHABET    = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  sasm_in_if.sink          text_in,
  sasm_out_if.source       result
);

  logic [LEN_W-1:0]       pattern_length;
  logic [INDEX_W-1:0]     text_index;
  logic                   accept;
  sasm_ctrl_t             ctrl;
  logic [MAX_PATTERN-1:0] state_vec;
  logic [MAX_PATTERN-1:0] next_vec;
  logic [63:0]            next_ext;
  logic                   hit;
  logic [INDEX_W-1:0]     start;
  logic                   new_match;
  logic [INDEX_W-1:0]     new_start;
  logic                   skid_valid;
  logic                   skid_match;
  logic [INDEX_W-1:0]     skid_start;
  logic                   pop;

  assign text_in.ready = !skid_valid;
  assign accept        = text_in.valid && text_in.ready;

  always_comb begin
    ctrl.clear  = accept && (text_in.opcode == OP_CLEAR);
    ctrl.load   = accept && (text_in.opcode == OP_LOAD);
    ctrl.text   = accept && (text_in.opcode == OP_TEXT);
    ctrl.sym_ok = (32'(text_in.symbol) < ALPHABET);
    ctrl.symbol = text_in.symbol;
  end

  for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
    logic load_sel;
    logic prev_bit;

    assign load_sel = ctrl.load && ctrl.sym_ok && (text_in.position == POS_W'(p));
    if (p == 0) begin : g_first
      assign prev_bit = 1'b1;
    end else begin : g_rest
      assign prev_bit = state_vec[p-1];
    end

    sasm_cell #(
      .ALPHABET (ALPHABET)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .load_sel  (load_sel),
      .prev_bit  (prev_bit),
      .state_bit (state_vec[p]),
      .next_bit  (next_vec[p])
    );
  end

  // Bits above the pattern width read as zero, so an overlong length never matches.
  assign next_ext  = 64'(next_vec);
  assign hit       = (pattern_length != '0) && next_ext[pattern_length - LEN_W'(1)];
  assign start     = text_index - INDEX_W'(pattern_length) + INDEX_W'(1);
  assign new_match = ctrl.text && hit;
  assign new_start = new_match ? start : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
    end else if (cfg_wr_en) begin
      pattern_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      text_index <= '0;
    end else if (ctrl.text) begin
      text_index <= text_index + INDEX_W'(1);
    end
  end

  assign pop = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        result.valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (!result.valid || pop) begin
      result.valid <= accept;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        result.match       <= skid_match;
        result.match_start <= skid_start;
      end
    end else if (!result.valid || pop) begin
      result.match       <= new_match;
      result.match_start <= new_start;
    end else if (accept) begin
      skid_match <= new_match;
      skid_start <= new_start;
    end
  end

endmodule

>>> rtl/core/sasm_checker.sv
// Port-level checks on the matcher, attached to the top level by a bind statement.
// Depends on sasm_pkg for the index width.
module sasm_checker import sasm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_match,
  input logic [INDEX_W-1:0] out_start
);

  // A held result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction withdrawn before it was taken");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_match |-> out_start == '0)
    else $error("start index is not zero on a result without a match");

  // With one result waiting, a second accepted transaction fills the output stage.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_valid && in_ready |=> !in_ready)
    else $error("input still ready with two results waiting");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind shift_and_string_matcher sasm_checker u_sasm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text_in.valid),
  .in_ready  (text_in.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_match (result.match),
  .out_start (result.match_start)
);

>>> dv/shift_and_string_matcher_tb.sv
// Self-checking testbench for the Shift-And string matcher: a directed table, then random
// phases of pattern loads and text under varied pattern lengths, with random flow control.
// Depends on sasm_pkg, sasm_in_if, sasm_out_if and shift_and_string_matcher.
module shift_and_string_matcher_tb;
  import sasm_pkg::*;

  localparam int MAXP = 63;
  localparam int ALPHA = 26;
  localparam int LIMIT = 300000;
  localparam int TEXT_PER_PHASE = 45;
  localparam int NUM_PHASES = 11;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] start;
  } match_rec_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [SYMBOL_W-1:0] sym;
    logic [POS_W-1:0]    pos;
    bit                  typed;
    logic                hit;
    logic [INDEX_W-1:0]  start;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  sasm_in_if  text_if ();
  sasm_out_if res_if ();

  shift_and_string_matcher uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .text_in    (text_if),
    .result     (res_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [MAXP-1:0]    sym_masks [ALPHA];
  logic [MAXP-1:0]    match_vec;
  logic [INDEX_W-1:0] text_pos;
  logic [LEN_W-1:0]   pat_len;

  match_rec_t pending_matches [$];
  int fails = 0;
  int burst_left = 0;
  bit hold_req = 0;
  int alpha_base;
  int alpha_n;
  logic [SYMBOL_W-1:0] pattern [MAXP];
  dir_row_t directed_rows [0:20];

  function automatic match_rec_t compute_match(logic [OPCODE_W-1:0] op,
                                               logic [SYMBOL_W-1:0] sym,
                                               logic [POS_W-1:0] pos);
    match_rec_t r;
    logic [MAXP-1:0] m;
    r.hit = 1'b0;
    r.start = '0;
    case (op)
      OP_CLEAR: begin
        for (int k = 0; k < ALPHA; k++) sym_masks[k] = '0;
        match_vec = '0;
        text_pos = '0;
      end
      OP_LOAD: begin
        if (sym < ALPHA && pos < MAXP) sym_masks[sym][pos] = 1'b1;
      end
      OP_TEXT: begin
        m = (sym < ALPHA) ? sym_masks[sym] : '0;
        match_vec = ((match_vec << 1) | 1) & m;
        if (pat_len >= 1 && pat_len <= MAXP && match_vec[pat_len - 1]) begin
          r.hit = 1'b1;
          r.start = text_pos - INDEX_W'(pat_len) + 1;
        end
        text_pos = text_pos + 1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(input logic [OPCODE_W-1:0] op, input logic [SYMBOL_W-1:0] sym,
                      input logic [POS_W-1:0] pos, input bit typed, input logic hit,
                      input logic [INDEX_W-1:0] start);
    int gap;
    match_rec_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        text_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    text_if.valid <= 1'b1;
    text_if.opcode <= op;
    text_if.symbol <= sym;
    text_if.position <= pos;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    r = compute_match(op, sym, pos);
    if (typed) begin
      r.hit = hit;
      r.start = start;
    end
    pending_matches.push_back(r);
    burst_left--;
  endtask

  task automatic send_text(input logic [SYMBOL_W-1:0] sym);
    send(OP_TEXT, sym, POS_W'($urandom_range(0, 63)), 1'b0, 1'b0, '0);
  endtask

  task automatic wait_drained();
    text_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pat_len = len;
  endtask

  function automatic logic [SYMBOL_W-1:0] pick_letter();
    return SYMBOL_W'(alpha_base + $urandom_range(0, alpha_n - 1));
  endfunction

  task automatic report_mismatch(input string what, input match_rec_t exp_r,
                                 input match_rec_t got_r);
    if (fails < 10)
      $display("mismatch (%s): expected match=%0b start=%0d, got match=%0b start=%0d",
               what, exp_r.hit, exp_r.start, got_r.hit, got_r.start);
    fails++;
  endtask

  always @(posedge clk) begin
    match_rec_t got_r;
    match_rec_t exp_r;
    if (!rst && res_if.valid && res_if.ready) begin
      got_r.hit = res_if.match;
      got_r.start = res_if.match_start;
      if (pending_matches.size() == 0) begin
        report_mismatch("unexpected transaction", '0, got_r);
      end else begin
        exp_r = pending_matches.pop_front();
        if (got_r.hit !== exp_r.hit || got_r.start !== exp_r.start)
          report_mismatch("result fields", exp_r, got_r);
      end
    end
  end

  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int tick;
    logic rdy;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 9) != 0);
          default: rdy = (tick % 3 != 0);
        endcase
      end
      res_if.ready <= rdy;
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("[shift_and_string_matcher] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int phase_len [NUM_PHASES];
    int load_len;
    int text_sent;
    int r;
    int mut;
    bit pressed;
    logic [OPCODE_W-1:0] op;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    text_if.valid = 1'b0;
    text_if.opcode = OP_CLEAR;
    text_if.symbol = '0;
    text_if.position = '0;
    for (int k = 0; k < ALPHA; k++) sym_masks[k] = '0;
    match_vec = '0;
    text_pos = '0;
    pat_len = 1;

    directed_rows = '{
      '{OP_TEXT,   5'd0,  6'd0,  1'b1, 1'b0, 32'd0},
      '{OP_LOAD,   5'd0,  6'd0,  1'b1, 1'b0, 32'd0},
      '{OP_TEXT,   5'd0,  6'd5,  1'b1, 1'b1, 32'd1},
      '{OP_TEXT,   5'd31, 6'd63, 1'b1, 1'b0, 32'd0},
      '{OP_LOAD,   5'd31, 6'd0,  1'b1, 1'b0, 32'd0},
      '{OP_TEXT,   5'd31, 6'd0,  1'b1, 1'b0, 32'd0},
      '{OP_LOAD,   5'd25, 6'd63, 1'b1, 1'b0, 32'd0},
      '{OP_TEXT,   5'd25, 6'd0,  1'b1, 1'b0, 32'd0},
      '{OP_LOAD,   5'd25, 6'd62, 1'b1, 1'b0, 32'd0},
      '{OP_TEXT,   5'd25, 6'd42, 1'b0, 1'b0, 32'd0},
      '{OP_UNUSED, 5'd31, 6'd63, 1'b1, 1'b0, 32'd0},
      '{OP_TEXT,   5'd0,  6'd21, 1'b0, 1'b0, 32'd0},
      '{OP_LOAD,   5'd1,  6'd1,  1'b1, 1'b0, 32'd0},
      '{OP_LOAD,   5'd0,  6'd2,  1'b1, 1'b0, 32'd0},
      '{OP_TEXT,   5'd0,  6'd0,  1'b0, 1'b0, 32'd0},
      '{OP_TEXT,   5'd1,  6'd0,  1'b0, 1'b0, 32'd0},
      '{OP_TEXT,   5'd0,  6'd0,  1'b0, 1'b0, 32'd0},
      '{OP_CLEAR,  5'd31, 6'd63, 1'b1, 1'b0, 32'd0},
      '{OP_TEXT,   5'd0,  6'd0,  1'b1, 1'b0, 32'd0},
      '{OP_LOAD,   5'd0,  6'd0,  1'b1, 1'b0, 32'd0},
      '{OP_TEXT,   5'd0,  6'd0,  1'b1, 1'b1, 32'd1}
    };

    phase_len = '{63, 0, 1, 2, 5, 63, 3, 0, 0, 0, 0};
    for (int p = 7; p < NUM_PHASES; p++) phase_len[p] = $urandom_range(1, 63);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].pos,
           directed_rows[i].typed, directed_rows[i].hit, directed_rows[i].start);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_length(LEN_W'(phase_len[p]));
      alpha_n = $urandom_range(1, 3);
      alpha_base = $urandom_range(0, ALPHA - alpha_n);
      load_len = (phase_len[p] == 0) ? 4 : phase_len[p];
      send(OP_CLEAR, SYMBOL_W'($urandom_range(0, 31)), POS_W'($urandom_range(0, 63)),
           1'b0, 1'b0, '0);
      for (int i = 0; i < load_len; i++) begin
        pattern[i] = pick_letter();
        send(OP_LOAD, pattern[i], POS_W'(i), 1'b0, 1'b0, '0);
      end
      text_sent = 0;
      pressed = 1'b0;
      while (text_sent < TEXT_PER_PHASE) begin
        if ((p == 1 || p == 5) && !pressed && text_sent >= 20) begin
          hold_req = 1;
          pressed = 1'b1;
        end
        if (p == 3 && !pressed && text_sent >= 35) begin
          wait_drained();
          pressed = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
          op = (r == 0) ? OP_CLEAR : OPCODE_W'($urandom_range(1, 3));
          send(op, SYMBOL_W'($urandom_range(0, 31)), POS_W'($urandom_range(0, 63)),
               1'b0, 1'b0, '0);
          if (op == OP_TEXT) text_sent++;
        end else if (r < 50) begin
          mut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, load_len - 1) : -1;
          for (int i = 0; i < load_len; i++)
            send_text((i == mut) ? pick_letter() : pattern[i]);
          text_sent += load_len;
        end else begin
          send_text(pick_letter());
          text_sent++;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fails == 0 && pending_matches.size() == 0) begin
      $display("[shift_and_string_matcher] OK");
    end else begin
      $display("[shift_and_string_matcher] ERROR");
    end
    $finish;
  end

endmodule
